FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the mixer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the reset expression is high.
`define XMIX_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mixer check failed");

// Next-cycle implication, disabled while the reset expression is high.
`define XMIX_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mixer check failed");

`endif

FILE: rtl/core/xmix_pkg.sv
// Package for the crosspoint mixer: sizes, field offsets, codes, state encoding,
// controller/datapath command structs and the quarter-sine pan table.
// No dependencies.
package xmix_pkg;

  localparam int NUM_SOURCES = 64;
  localparam int NUM_DESTS   = 32;
  localparam int SAMPLE_BITS = 24;

  localparam int SRC_W   = $clog2(NUM_SOURCES);
  localparam int DEST_W  = $clog2(NUM_DESTS);
  localparam int TAB_AW  = SRC_W + DEST_W;
  localparam int TAB_DEPTH = NUM_SOURCES * NUM_DESTS;
  localparam int GAIN_W  = 16;
  localparam int PAN_W   = 16;
  localparam int PG_W    = 16;
  localparam int PRODW_W = GAIN_W + PG_W;
  localparam int COEF_W  = 18;
  localparam int ACC_W   = 48;
  localparam int MAC_W   = SAMPLE_BITS + COEF_W + 1;
  localparam int CNT_W   = TAB_AW;
  localparam int HWC_W   = 6;
  localparam int MASK_W  = 32;

  // Input item layout in tdata, lowest field first.
  localparam int SRC_LO  = 0;
  localparam int DST_LO  = SRC_LO + SRC_W;
  localparam int EN_BIT  = DST_LO + DEST_W;
  localparam int MUTE_BIT = EN_BIT + 1;
  localparam int GAIN_LO = MUTE_BIT + 1;
  localparam int PAN_LO  = GAIN_LO + GAIN_W;
  localparam int SMP_LO  = PAN_LO + PAN_W;
  localparam int IN_FIELDS_W = SMP_LO + SAMPLE_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_FIELDS_W = DEST_W + SAMPLE_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_DATA_W = 32;

  localparam logic [PRODW_W-1:0] COEF_FLOOR = PRODW_W'(5369);
  localparam logic [PRODW_W-1:0] COEF_ROUND = PRODW_W'(4096);
  localparam logic [DEST_W-1:0]  DEST_LAST  = DEST_W'(NUM_DESTS - 1);
  localparam logic [CNT_W-1:0]   CLEAR_LAST = CNT_W'(TAB_DEPTH - 1);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic CFG_HW_COUNT = 1'b0;
  localparam logic CFG_LOOPBACK = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_PAN,
    ST_WR_MUL,
    ST_WR_STORE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              clear_en;
    logic [CNT_W-1:0]  clear_addr;
    logic              pg_en;
    logic              prod_en;
    logic              coef_wr;
    logic              mac_issue;
    logic              emit_load;
    logic [DEST_W-1:0] dest;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic frame_end;
  } status_t;

  // Quarter-sine table: sin(k*pi/512) in Q1.15 from an integer Taylor series.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [PG_W-1:0] sine_rom_t [256];

  function automatic logic [PG_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] t;
    longint      sum;
    x = (64'(k) * HALF_PI_Q30) / 64'd256;
    t = x;
    sum = longint'(x);
    for (int n = 0; n < 8; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DIV[n];
      if (n % 2 == 0) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32768) sum = 32768;
    return PG_W'(sum);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < 256; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam logic [PG_W-1:0] SINE_TOP = sine_entry(256);

endpackage

FILE: rtl/core/xmix_ctrl.sv
// Sequencer of the crosspoint mixer: clearing pass, crosspoint write steps,
// multiply-accumulate sweep and frame output sweep. Depends on xmix_pkg.
module xmix_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  xmix_pkg::status_t  status,
  output xmix_pkg::cmd_t     cmd
);

  xmix_pkg::state_t state, state_next;
  logic [xmix_pkg::CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xmix_pkg::ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.dest       = cnt[xmix_pkg::DEST_W-1:0];
    cmd.clear_addr = cnt;
    case (state)
      xmix_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (cnt == xmix_pkg::CLEAR_LAST) begin
          cnt_next   = '0;
          state_next = xmix_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      xmix_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          if (in_op == xmix_pkg::OP_SAMPLE) state_next = xmix_pkg::ST_MAC;
          else state_next = xmix_pkg::ST_WR_PAN;
        end
      end
      xmix_pkg::ST_WR_PAN: begin
        cmd.pg_en  = 1'b1;
        state_next = xmix_pkg::ST_WR_MUL;
      end
      xmix_pkg::ST_WR_MUL: begin
        cmd.prod_en = 1'b1;
        state_next  = xmix_pkg::ST_WR_STORE;
      end
      xmix_pkg::ST_WR_STORE: begin
        cmd.coef_wr = 1'b1;
        state_next  = xmix_pkg::ST_IDLE;
      end
      xmix_pkg::ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (cnt[xmix_pkg::DEST_W-1:0] == xmix_pkg::DEST_LAST) begin
          cnt_next   = '0;
          state_next = xmix_pkg::ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      xmix_pkg::ST_DRAIN: begin
        if (cnt[0]) begin
          cnt_next = '0;
          if (status.frame_end) state_next = xmix_pkg::ST_EMIT;
          else state_next = xmix_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      xmix_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (cnt[xmix_pkg::DEST_W-1:0] == xmix_pkg::DEST_LAST) begin
            cnt_next   = '0;
            state_next = xmix_pkg::ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        cnt_next   = '0;
        state_next = xmix_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/xmix_dp.sv
// Datapath of the crosspoint mixer: item and configuration registers, pan and
// coefficient arithmetic, coefficient memory, accumulators and output register.
// Depends on xmix_pkg; driven by xmix_ctrl.
module xmix_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  xmix_pkg::cmd_t                    cmd,
  output xmix_pkg::status_t                 status,
  input  logic [xmix_pkg::IN_DATA_W-1:0]    item_data,
  input  logic                              item_last,
  input  logic                              cfg_wr,
  input  logic                              cfg_sel,
  input  logic [xmix_pkg::CFG_DATA_W-1:0]   cfg_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [xmix_pkg::OUT_DATA_W-1:0]   out_data,
  output logic [1:0]                        out_flags,
  output logic                              out_last
);

  localparam int SW = xmix_pkg::SAMPLE_BITS;
  localparam int AW = xmix_pkg::ACC_W;

  logic [xmix_pkg::HWC_W-1:0]  hw_count;
  logic [xmix_pkg::MASK_W-1:0] loop_mask;

  logic [xmix_pkg::SRC_W-1:0]   src_q;
  logic [xmix_pkg::DEST_W-1:0]  dst_q;
  logic                         en_q;
  logic                         mute_q;
  logic [xmix_pkg::GAIN_W-1:0]  gain_q;
  logic signed [xmix_pkg::PAN_W-1:0] pan_q;
  logic signed [SW-1:0]         smp_q;
  logic                         fend_q;

  logic signed [xmix_pkg::PAN_W-1:0] pan_c;
  logic signed [xmix_pkg::PAN_W:0]   pan_sum;
  logic [xmix_pkg::PAN_W:0]          k_sum;
  logic [8:0]                        rom_k;
  logic [8:0]                        rom_idx;
  logic [xmix_pkg::PG_W-1:0]         pg;
  logic [xmix_pkg::PG_W-1:0]         pg_q;
  logic [xmix_pkg::PRODW_W-1:0]      prod_wr;
  logic [xmix_pkg::PRODW_W-1:0]      coef_rnd;
  logic [xmix_pkg::COEF_W-1:0]       coef;

  logic [xmix_pkg::COEF_W-1:0] coef_mem [xmix_pkg::TAB_DEPTH];
  logic                        mem_we;
  logic [xmix_pkg::TAB_AW-1:0] mem_waddr;
  logic [xmix_pkg::COEF_W-1:0] mem_wdata;
  logic [xmix_pkg::COEF_W-1:0] mem_rdata;

  logic                          v1, v2;
  logic [xmix_pkg::DEST_W-1:0]   d1, d2;
  logic signed [xmix_pkg::MAC_W-1:0] mac_prod;

  logic signed [AW-1:0] acc [xmix_pkg::NUM_DESTS];
  logic signed [AW-1:0] acc_rd;
  logic signed [AW:0]   acc_sum;
  logic signed [AW-1:0] acc_sat;

  logic signed [AW-1:0]   acc_e;
  logic signed [AW:0]     acc_rnd;
  logic signed [AW-16:0]  quot;
  logic signed [SW-1:0]   mix;
  logic                   hw;
  logic                   lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      hw_count  <= xmix_pkg::HWC_W'(20);
      loop_mask <= xmix_pkg::MASK_W'(3);
    end else if (cfg_wr) begin
      if (cfg_sel == xmix_pkg::CFG_HW_COUNT) hw_count <= cfg_value[xmix_pkg::HWC_W-1:0];
      else loop_mask <= cfg_value[xmix_pkg::MASK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_q  <= item_data[xmix_pkg::SRC_LO +: xmix_pkg::SRC_W];
      dst_q  <= item_data[xmix_pkg::DST_LO +: xmix_pkg::DEST_W];
      en_q   <= item_data[xmix_pkg::EN_BIT];
      mute_q <= item_data[xmix_pkg::MUTE_BIT];
      gain_q <= item_data[xmix_pkg::GAIN_LO +: xmix_pkg::GAIN_W];
      pan_q  <= item_data[xmix_pkg::PAN_LO +: xmix_pkg::PAN_W];
      smp_q  <= item_data[xmix_pkg::SMP_LO +: SW];
      fend_q <= item_last;
    end
  end

  assign status.frame_end = fend_q;
  assign status.out_free  = !out_valid || out_ready;

  // Pan angle to table index; even destinations read the mirrored entry.
  always_comb begin
    if (pan_q > 16'sd16384) pan_c = 16'sd16384;
    else if (pan_q < -16'sd16384) pan_c = -16'sd16384;
    else pan_c = pan_q;
    pan_sum = {pan_c[xmix_pkg::PAN_W-1], pan_c} + 17'sd16384;
    k_sum   = {1'b0, pan_sum[xmix_pkg::PAN_W-1:0]} + 17'd64;
    rom_k   = k_sum[15:7];
    rom_idx = dst_q[0] ? rom_k : 9'd256 - rom_k;
    pg      = rom_idx[8] ? xmix_pkg::SINE_TOP : xmix_pkg::SINE_ROM[rom_idx[7:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.pg_en) pg_q <= pg;
    if (cmd.prod_en) prod_wr <= xmix_pkg::PRODW_W'(gain_q) * xmix_pkg::PRODW_W'(pg_q);
  end

  always_comb begin
    coef_rnd = prod_wr + xmix_pkg::COEF_ROUND;
    if (en_q && !mute_q && prod_wr >= xmix_pkg::COEF_FLOOR) coef = coef_rnd[30:13];
    else coef = '0;
  end

  assign mem_we    = cmd.clear_en || cmd.coef_wr;
  assign mem_waddr = cmd.clear_en ? cmd.clear_addr : {src_q, dst_q};
  assign mem_wdata = cmd.clear_en ? '0 : coef;

  always_ff @(posedge clk) begin
    if (mem_we) coef_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= coef_mem[{src_q, cmd.dest}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
    d1       <= cmd.dest;
    d2       <= d1;
    mac_prod <= smp_q * $signed({1'b0, mem_rdata});
  end

  always_comb begin
    acc_rd  = acc[d2];
    acc_sum = {acc_rd[AW-1], acc_rd} + {{(AW + 1 - xmix_pkg::MAC_W){mac_prod[xmix_pkg::MAC_W-1]}},
                                        mac_prod};
    if (acc_sum[AW] != acc_sum[AW-1]) acc_sat = {acc_sum[AW], {(AW - 1){!acc_sum[AW]}}};
    else acc_sat = acc_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < xmix_pkg::NUM_DESTS; i++) acc[i] <= '0;
    end else if (cmd.emit_load) begin
      acc[cmd.dest] <= '0;
    end else if (v2) begin
      acc[d2] <= acc_sat;
    end
  end

  // Round to nearest at the Q16 point, then saturate to the sample width.
  always_comb begin
    acc_e   = acc[cmd.dest];
    acc_rnd = {acc_e[AW-1], acc_e} + (AW + 1)'(32768);
    quot    = acc_rnd[AW:16];
    if ((&quot[AW-16:SW-1]) || !(|quot[AW-16:SW-1])) mix = quot[SW-1:0];
    else mix = {quot[AW-16], {(SW - 1){!quot[AW-16]}}};
    hw = {1'b0, cmd.dest} < hw_count;
    lb = hw && loop_mask[cmd.dest];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit_load) begin
      out_data  <= xmix_pkg::OUT_DATA_W'({mix, cmd.dest});
      out_flags <= {lb, hw};
      out_last  <= cmd.dest == xmix_pkg::DEST_LAST;
    end
  end

endmodule

FILE: rtl/core/crosspoint_audio_mix_matrix_top.sv
// Top level of the crosspoint audio mixer with constant-power pan.
// Depends on xmix_pkg, xmix_ctrl and xmix_dp.
//
// Input stream s_axis_*: tuser selects the item kind (crosspoint write or
// source sample), tlast marks the last sample of a sample period.
// A crosspoint write steps through table index, gain multiply and store.
// A sample item issues one multiply-accumulate per destination through the
// single coefficient memory read port, then drains the pipeline.
// With tlast set, 32 result items follow, one per destination in order,
// at one per cycle while m_axis_tready stays high; the sweep pauses while
// the receiver stalls, and the accumulators are cleared as they are read.
// The next input item is taken as soon as the last result is in the
// output register.
// Configuration writes on cfg_* are always accepted and must be made while
// the block is idle.
// After reset the coefficient memory is cleared, one entry a cycle, all 2048
// entries; s_axis_tready stays low until then.
module crosspoint_audio_mix_matrix_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // source, dest, enabled, mute, gain, pan, sample, zero padding
  input  logic [xmix_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_dest, mix_sample, zero padding
  output logic [xmix_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // to_hw_output, to_loopback
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [xmix_pkg::CFG_DATA_W-1:0]   cfg_data
);

  xmix_pkg::cmd_t    cmd;
  xmix_pkg::status_t status;

  assign cfg_ready = 1'b1;

  xmix_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  xmix_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item_data (s_axis_tdata),
    .item_last (s_axis_tlast),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_value (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_flags (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: rtl/core/xmix_checker.sv
// Port-level checks of the crosspoint mixer output stream, bound to the top level.
// Depends on xmix_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xmix_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [xmix_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [1:0]                        m_axis_tuser,
  input logic                              m_axis_tlast
);

  `XMIX_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid)
  `XMIX_ASSERT_NXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `XMIX_ASSERT_IMP(a_loop_needs_hw, clk, rst, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
  `XMIX_ASSERT_IMP(a_last_dest, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[xmix_pkg::DEST_W-1:0] == xmix_pkg::DEST_LAST)
  `XMIX_ASSERT_NXT(a_dest_order, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid || m_axis_tdata[xmix_pkg::DEST_W-1:0] == xmix_pkg::DEST_W'($past(m_axis_tdata[xmix_pkg::DEST_W-1:0]) + 1'b1))

endmodule

bind crosspoint_audio_mix_matrix_top xmix_checker u_xmix_checker (.*);
